// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg: shared types and constants
// Widths, defaults and the command and release records passed between the
// front end, the command queue and the back end of the group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int DATA_W            = 32;
  localparam int CFG_W             = 5;
  localparam int MAX_GROUP_DEFAULT = 16;
  localparam int MAX_GROUP_LIMIT   = 64;
  // Count field wide enough for the largest group the parameter allows.
  localparam int CNT_W             = $clog2(MAX_GROUP_LIMIT + 1);

  // One emission run: which bank, how many entries, which direction, and whether it ends the stream.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             rev;
    logic             fin;
  } sgr_cmd_t;

  // Back end hands a bank back to the front end once fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } sgr_rel_t;

endpackage

// ===== rtl/sgr_front.sv =====
// ----------------------------------------------------------------------------
// sgr_front: request intake and group store
// Holds the group size register, writes requests into a two-bank store and
// issues one emission command per completed group or stream tail.
// ----------------------------------------------------------------------------
module sgr_front #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEFAULT,
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [sgr_pkg::DATA_W-1:0] value,
  input  logic                            final_item,
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output sgr_pkg::sgr_cmd_t               cmd,
  input  sgr_pkg::sgr_rel_t               rel,
  input  logic                            rd_en,
  input  logic [IDX_W:0]                  rd_addr,
  output logic [sgr_pkg::DATA_W-1:0]      rd_data
);

  localparam int DEPTH = 2 ** (IDX_W + 1);

  logic [sgr_pkg::DATA_W-1:0] mem [0:DEPTH-1];

  logic [sgr_pkg::CFG_W-1:0] group_size;
  logic [sgr_pkg::CNT_W-1:0] fill;
  logic                      wbank;
  logic [1:0]                busy, busy_next;

  logic [sgr_pkg::CNT_W-1:0] gs_ext, k_eff, n_new;
  logic                      in_fire, full_group, done;

  always_comb begin
    gs_ext = sgr_pkg::CNT_W'(group_size);
    if (group_size == '0) begin
      k_eff = sgr_pkg::CNT_W'(1);
    end else if (gs_ext > sgr_pkg::CNT_W'(MAX_GROUP)) begin
      k_eff = sgr_pkg::CNT_W'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign in_ready   = !busy[wbank] && cmd_ready;
  assign in_fire    = in_valid && in_ready;
  assign n_new      = fill + sgr_pkg::CNT_W'(1);
  assign full_group = n_new >= k_eff;
  assign done       = full_group || final_item;

  assign cmd_valid  = in_fire && done;
  assign cmd.bank   = wbank;
  assign cmd.count  = n_new;
  assign cmd.rev    = full_group;
  assign cmd.fin    = final_item;

  // Released bank and newly closed bank are never the same one.
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (in_fire && done) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[{wbank, fill[IDX_W-1:0]}] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= sgr_pkg::CFG_W'(1);
      fill       <= '0;
      wbank      <= 1'b0;
      busy       <= '0;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_data;
      end
      busy <= busy_next;
      if (in_fire) begin
        if (done) begin
          fill  <= '0;
          wbank <= !wbank;
        end else begin
          fill <= n_new;
        end
      end
    end
  end

endmodule

// ===== rtl/sgr_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// sgr_cmd_queue: two-entry command queue
// Decouples the intake side from the emission side.
// ----------------------------------------------------------------------------
module sgr_cmd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  sgr_pkg::sgr_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sgr_pkg::sgr_cmd_t pop_data
);

  sgr_pkg::sgr_cmd_t e0, e1;
  logic [1:0]        cnt;
  logic              push, pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = e0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd1) begin
        e0 <= push_data;
      end else begin
        e0 <= e1;
        e1 <= push_data;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

endmodule

// ===== rtl/sgr_back.sv =====
// ----------------------------------------------------------------------------
// sgr_back: emission sequencer
// Walks one command's bank forward or backward, one read a cycle while the
// output stage has room, and buffers results in a two-entry output stage.
// ----------------------------------------------------------------------------
module sgr_back #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEFAULT,
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  sgr_pkg::sgr_cmd_t                 cmd,
  output sgr_pkg::sgr_rel_t                 rel,
  output logic                              rd_en,
  output logic [IDX_W:0]                    rd_addr,
  input  logic [sgr_pkg::DATA_W-1:0]        rd_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sgr_pkg::DATA_W-1:0] value_out,
  output logic                              run_end,
  output logic                              stream_end
);

  typedef struct packed {
    logic [sgr_pkg::DATA_W-1:0] data;
    logic                       run_end;
    logic                       stream_end;
  } res_t;

  logic [sgr_pkg::CNT_W-1:0] idx, offset;
  logic                      last, issue, pop, push;
  logic                      pend, pend_run_end, pend_stream_end;
  logic [1:0]                cnt;
  logic [2:0]                occ;
  res_t                      e0, e1, new_res;

  assign pop = out_valid && out_ready;
  assign occ = 3'(cnt) + 3'(pend);
  // Room when what is buffered or in flight fits after this cycle's take.
  assign issue = cmd_valid && ((occ < 3'd2) || (pop && occ < 3'd3));

  assign last   = (idx == cmd.count - sgr_pkg::CNT_W'(1));
  assign offset = cmd.rev ? (cmd.count - sgr_pkg::CNT_W'(1) - idx) : idx;

  assign rd_en     = issue;
  assign rd_addr   = {cmd.bank, offset[IDX_W-1:0]};
  assign cmd_ready = issue && last;
  assign rel.valid = issue && last;
  assign rel.bank  = cmd.bank;

  assign push               = pend;
  assign new_res.data       = rd_data;
  assign new_res.run_end    = pend_run_end;
  assign new_res.stream_end = pend_stream_end;

  assign out_valid  = (cnt != 2'd0);
  assign value_out  = e0.data;
  assign run_end    = e0.run_end;
  assign stream_end = e0.stream_end;

  always_ff @(posedge clk) begin
    pend_run_end    <= last;
    pend_stream_end <= last && cmd.fin;
    if (push && pop) begin
      if (cnt == 2'd1) begin
        e0 <= new_res;
      end else begin
        e0 <= e1;
        e1 <= new_res;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= new_res;
      end else begin
        e1 <= new_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
      cnt  <= '0;
    end else begin
      pend <= issue;
      if (issue) begin
        idx <= last ? '0 : idx + sgr_pkg::CNT_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/stream_group_reverser.sv =====
// ----------------------------------------------------------------------------
// stream_group_reverser: reorders a value stream in groups
// Top level joining intake, command queue and emission sequencer.
// ----------------------------------------------------------------------------
// Requests carry a signed 32-bit value and a final flag. Requests collect in
// one bank of a two-bank group store; when group_size requests have arrived
// the group is emitted newest first, and when a final request arrives before
// the group fills, the buffered requests are emitted oldest first. run_end
// marks the last result of each run, stream_end the last result caused by a
// final request. A request is taken while a bank is free, so one group
// fills while the previous one drains. Results leave at one per cycle
// while out_ready is high, set by the store's single read port; a run passes
// the command queue, the registered store read and the output buffer. Intake
// stalls only when both banks hold runs not yet fully read. group_size is
// 0 -> 1 and saturates at MAX_GROUP; write it only while the block is idle.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [sgr_pkg::CFG_W-1:0]         cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sgr_pkg::DATA_W-1:0] value,
  input  logic                              final_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sgr_pkg::DATA_W-1:0] value_out,
  output logic                              run_end,
  output logic                              stream_end
);

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  sgr_pkg::sgr_cmd_t          f_cmd, b_cmd;
  sgr_pkg::sgr_rel_t          rel;
  logic                       f_cmd_valid, f_cmd_ready;
  logic                       b_cmd_valid, b_cmd_ready;
  logic                       rd_en;
  logic [IDX_W:0]             rd_addr;
  logic [sgr_pkg::DATA_W-1:0] rd_data;

  // Front: register, store writes, run classification.
  sgr_front #(
    .MAX_GROUP (MAX_GROUP),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .final_item (final_item),
    .cmd_valid  (f_cmd_valid),
    .cmd_ready  (f_cmd_ready),
    .cmd        (f_cmd),
    .rel        (rel),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // At most one run per bank is outstanding, so two entries suffice.
  sgr_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_cmd_valid),
    .push_ready (f_cmd_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_cmd_valid),
    .pop_ready  (b_cmd_ready),
    .pop_data   (b_cmd)
  );

  // Back: reads a bank in run order and drives the result channel.
  sgr_back #(
    .MAX_GROUP (MAX_GROUP),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (b_cmd_valid),
    .cmd_ready  (b_cmd_ready),
    .cmd        (b_cmd),
    .rel        (rel),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_out  (value_out),
    .run_end    (run_end),
    .stream_end (stream_end)
  );

endmodule

// ===== rtl/sgr_checker.sv =====
// ----------------------------------------------------------------------------
// sgr_checker: port-level checks
// Watches the top level's ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sgr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sgr_pkg::DATA_W-1:0] value_out,
  input logic                       run_end,
  input logic                       stream_end
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_out)
      && $stable(run_end) && $stable(stream_end))
    else $error("stalled result changed");

  // End of stream always closes a run.
  a_stream_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_end)
    else $error("stream_end without run_end");

  // Nothing is shown right after reset.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Both banks are free after reset.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("intake not ready after reset");

endmodule

bind stream_group_reverser sgr_checker u_sgr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .value_out  (value_out),
  .run_end    (run_end),
  .stream_end (stream_end)
);
